// File: hw/rtl/brf_pkg.sv
`timescale 1ns / 1ps

package brf_pkg;

    // Default byte store depth
    localparam int DEPTH_DEFAULT = 4096;

    // Field widths
    localparam int CFG_W  = 4;
    localparam int OP_W   = 3;
    localparam int BYTE_W = 8;
    localparam int CNT_W  = 13;

    // Stream payload widths (whole bytes)
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 80;

    // Capacity after reset, as log2 of bytes
    localparam logic [CFG_W-1:0] CAP_LOG2_RESET = 4'd12;

    // Operation codes
    localparam logic [OP_W-1:0] OP_PUSH    = 3'd0;
    localparam logic [OP_W-1:0] OP_POP     = 3'd1;
    localparam logic [OP_W-1:0] OP_PEEK    = 3'd2;
    localparam logic [OP_W-1:0] OP_DRAIN   = 3'd3;
    localparam logic [OP_W-1:0] OP_POKE    = 3'd4;
    localparam logic [OP_W-1:0] OP_ADVANCE = 3'd5;
    localparam logic [OP_W-1:0] OP_CLEAR   = 3'd6;

endpackage

// File: hw/rtl/byte_ring_fifo_core.sv
`timescale 1ns / 1ps

// Channel   | Dir | Signals                            | Content
// ----------+-----+------------------------------------+----------------------------------
// s_axis    | in  | i_s_axis_tvalid/o_s_axis_tready    | one operation item (tdata)
// m_axis    | out | o_m_axis_tvalid/i_m_axis_tready    | one result item per operation
// cfg       | in  | i_cfg_wr_en/i_cfg_wr_data          | capacity_log2, empties the FIFO
//
// One item per cycle sustained while the output is not stalled; a result passes through the
// byte store read register, then the status/output register.
// The byte store has one write and one registered read port; pointer and level
// registers update at accept, so the next item sees them with no interlock.
// Reset (i_rst_n low, synchronous): empty FIFO, capacity 2^12 bytes clamped to DEPTH.
// The store itself is not cleared. Ready drops only when both the result register
// and the stage before it hold items and the output is stalled.

module byte_ring_fifo_core #(
    parameter int DEPTH = brf_pkg::DEPTH_DEFAULT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // capacity_log2
    input  logic                              i_cfg_wr_en,
    input  logic [brf_pkg::CFG_W-1:0]         i_cfg_wr_data,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // operation[2:0], data_in[10:3], amount[23:11]
    input  logic [brf_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // data_out[7:0], done_res[8], amount_done[21:9], peek_last[22], fill_level[35:23],
    // free_space[48:36], fill_contiguous[61:49], free_contiguous[74:62], zero[79:75]
    output logic [brf_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata
);

    localparam int CNT_W   = brf_pkg::CNT_W;
    localparam int MAXL    = $clog2(DEPTH + 1) - 1;
    localparam int AW      = MAXL;
    localparam int PW      = MAXL + 1;
    localparam int CW      = (PW > CNT_W) ? PW : CNT_W;
    localparam int ENTRIES = 1 << AW;
    localparam int RST_L   = (int'(brf_pkg::CAP_LOG2_RESET) > MAXL) ?
                             MAXL : int'(brf_pkg::CAP_LOG2_RESET);
    localparam logic [PW-1:0] RST_CAP   = PW'(1 << RST_L);
    localparam logic [PW-1:0] RST_PMASK = PW'((2 << RST_L) - 1);
    localparam logic [AW-1:0] RST_IMASK = AW'((1 << RST_L) - 1);

    // effective capacity: log2 clamped to 1..MAXL
    function automatic logic [PW-1:0] f_cap(input logic [brf_pkg::CFG_W-1:0] k_in);
        logic [4:0] k;
        k = {1'b0, k_in};
        if (k < 5'd1) k = 5'd1;
        if (k > 5'(MAXL)) k = 5'(MAXL);
        return PW'(1) << k;
    endfunction

    // input fields
    logic [brf_pkg::OP_W-1:0]   op;
    logic [brf_pkg::BYTE_W-1:0] din;
    logic [CNT_W-1:0]           amt;

    assign op  = i_s_axis_tdata[2:0];
    assign din = i_s_axis_tdata[10:3];
    assign amt = i_s_axis_tdata[23:11];

    // FIFO state
    logic [PW-1:0] r_cap, r_pmask, r_head, r_tail, r_fill, r_free;
    logic [AW-1:0] r_imask;
    logic [PW-1:0] n_cap, n_pmask, n_head, n_tail, n_fill, n_free;
    logic [AW-1:0] n_imask;

    // pipeline control
    logic r_s1_valid, r_o_valid;
    logic s_acc, out_free, s1_move;

    // stage 1 payload
    logic                       r_s1_done, r_s1_last, r_s1_use_rd;
    logic [CNT_W-1:0]           r_s1_adone;
    logic [brf_pkg::BYTE_W-1:0] r_rd_data;
    logic [brf_pkg::OUT_TDATA_W-1:0] r_tdata;

    // byte store
    logic [brf_pkg::BYTE_W-1:0] mem [ENTRIES];

    // op decode results
    logic             ok, last, use_rd, wr_en, rd_en;
    logic [AW-1:0]    wr_addr, rd_addr;
    logic [CNT_W-1:0] adone;
    logic [CW-1:0]    amt_c, fill_c, free_c;
    logic             lt_fill, lt_free;
    logic [PW-1:0]    amt_p, n_amt;
    logic [AW-1:0]    head_idx, tail_idx, peek_idx, poke_idx;

    // status of the state left by the item in stage 1
    logic [PW-1:0]    hrun, trun, fc, frc;
    logic [brf_pkg::BYTE_W-1:0] dout;

    // handshake
    assign out_free        = !r_o_valid || i_m_axis_tready;
    assign s1_move         = r_s1_valid && out_free;
    assign o_s_axis_tready = !r_s1_valid || out_free;
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = r_tdata;

    // capacity decode on a config write
    always_comb begin
        n_cap   = f_cap(i_cfg_wr_data);
        n_pmask = (n_cap << 1) - PW'(1);
        n_imask = AW'(n_cap - PW'(1));
    end

    // operation decode and next pointers
    always_comb begin
        amt_c    = CW'(amt);
        fill_c   = CW'(r_fill);
        free_c   = CW'(r_free);
        lt_fill  = amt_c < fill_c;
        lt_free  = amt_c < free_c;
        amt_p    = amt_c[PW-1:0];
        head_idx = r_head[AW-1:0] & r_imask;
        tail_idx = r_tail[AW-1:0] & r_imask;
        peek_idx = (r_head[AW-1:0] + amt_c[AW-1:0]) & r_imask;
        poke_idx = (r_tail[AW-1:0] + amt_c[AW-1:0]) & r_imask;

        n_head  = r_head;
        n_tail  = r_tail;
        n_fill  = r_fill;
        n_free  = r_free;
        n_amt   = '0;
        ok      = 1'b0;
        last    = 1'b0;
        use_rd  = 1'b0;
        wr_en   = 1'b0;
        rd_en   = 1'b0;
        wr_addr = tail_idx;
        rd_addr = head_idx;
        adone   = '0;

        case (op)
            brf_pkg::OP_PUSH: begin
                if (r_free != '0) begin
                    wr_en  = 1'b1;
                    n_tail = (r_tail + PW'(1)) & r_pmask;
                    n_fill = r_fill + PW'(1);
                    n_free = r_free - PW'(1);
                    ok     = 1'b1;
                end
            end
            brf_pkg::OP_POP: begin
                if (r_fill != '0) begin
                    rd_en  = 1'b1;
                    use_rd = 1'b1;
                    if (r_fill == PW'(1)) begin
                        n_head = '0;
                        n_tail = '0;
                    end else begin
                        n_head = (r_head + PW'(1)) & r_pmask;
                    end
                    n_fill = r_fill - PW'(1);
                    n_free = r_free + PW'(1);
                    ok     = 1'b1;
                end
            end
            brf_pkg::OP_PEEK: begin
                if (lt_fill) begin
                    rd_en   = 1'b1;
                    rd_addr = peek_idx;
                    use_rd  = 1'b1;
                    last    = (amt_c + CW'(1)) == fill_c;
                    ok      = 1'b1;
                end
            end
            brf_pkg::OP_DRAIN: begin
                n_amt = lt_fill ? amt_p : r_fill;
                if (lt_fill) begin
                    n_head = (r_head + n_amt) & r_pmask;
                end else begin
                    // drained to empty: both pointers back to zero
                    n_head = '0;
                    n_tail = '0;
                end
                n_fill = r_fill - n_amt;
                n_free = r_free + n_amt;
                adone  = CNT_W'(n_amt);
                ok     = 1'b1;
            end
            brf_pkg::OP_POKE: begin
                if (lt_free) begin
                    wr_en   = 1'b1;
                    wr_addr = poke_idx;
                    ok      = 1'b1;
                end
            end
            brf_pkg::OP_ADVANCE: begin
                n_amt  = lt_free ? amt_p : r_free;
                n_tail = (r_tail + n_amt) & r_pmask;
                n_fill = r_fill + n_amt;
                n_free = r_free - n_amt;
                adone  = CNT_W'(n_amt);
                ok     = 1'b1;
            end
            brf_pkg::OP_CLEAR: begin
                n_head = '0;
                n_tail = '0;
                n_fill = '0;
                n_free = r_cap;
                ok     = 1'b1;
            end
            default: begin
                ok = 1'b0;
            end
        endcase
    end

    // FIFO state and pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap      <= RST_CAP;
            r_pmask    <= RST_PMASK;
            r_imask    <= RST_IMASK;
            r_head     <= '0;
            r_tail     <= '0;
            r_fill     <= '0;
            r_free     <= RST_CAP;
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_cap   <= n_cap;
                r_pmask <= n_pmask;
                r_imask <= n_imask;
                r_head  <= '0;
                r_tail  <= '0;
                r_fill  <= '0;
                r_free  <= n_cap;
            end else if (s_acc) begin
                r_head <= n_head;
                r_tail <= n_tail;
                r_fill <= n_fill;
                r_free <= n_free;
            end
            if (s_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_o_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // byte store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (s_acc && wr_en) begin
            mem[wr_addr] <= din;
        end
        if (s_acc && rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // stage 1 payload
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_s1_done   <= ok;
            r_s1_last   <= last;
            r_s1_use_rd <= use_rd;
            r_s1_adone  <= adone;
        end
    end

    // level and contiguous runs; pointer registers hold the stage 1 item's result
    always_comb begin
        hrun = r_cap - PW'(head_idx);
        trun = r_cap - PW'(tail_idx);
        fc   = (r_fill < hrun) ? r_fill : hrun;
        frc  = (r_free < trun) ? r_free : trun;
        dout = r_s1_use_rd ? r_rd_data : '0;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_tdata <= {5'b0, CNT_W'(frc), CNT_W'(fc), CNT_W'(r_free), CNT_W'(r_fill),
                        r_s1_last, r_s1_adone, r_s1_done, dout};
        end
    end

    // level registers agree with the pointers
    a_level_sum : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        PW'(r_fill + r_free) == r_cap)
        else $error("fill plus free differs from capacity");

    a_level_ptr : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_tail - r_head) & r_pmask) == r_fill)
        else $error("fill register disagrees with pointer distance");

    a_ptr_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_head & ~r_pmask) == '0) && ((r_tail & ~r_pmask) == '0))
        else $error("pointer outside twice the capacity");

    a_fill_cap : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= r_cap)
        else $error("fill above capacity");

    a_stall_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_o_valid && !i_m_axis_tready) |-> !o_s_axis_tready)
        else $error("item taken while both stages are held");

endmodule

// File: dv/tb_byte_ring_fifo_core.sv
`timescale 1ns / 1ps

module tb_byte_ring_fifo_core;

    localparam int CLK_HALF        = 6;
    localparam int STORE_DEPTH     = brf_pkg::DEPTH_DEFAULT;
    localparam int MAX_CAP_LOG2    = $clog2(STORE_DEPTH + 1) - 1;
    localparam int RESULT_LATENCY  = 2;
    localparam int ITEMS_PER_PHASE = 50;
    localparam int AMOUNT_MAX      = (1 << brf_pkg::CNT_W) - 1;
    localparam logic [brf_pkg::OP_W-1:0] OP_UNUSED = 3'd7;

    // One result item, split into its fields
    typedef struct {
        logic [brf_pkg::BYTE_W-1:0] data_out;
        logic                       done;
        logic [brf_pkg::CNT_W-1:0]  amount_done;
        logic                       peek_last;
        logic [brf_pkg::CNT_W-1:0]  fill_level;
        logic [brf_pkg::CNT_W-1:0]  free_space;
        logic [brf_pkg::CNT_W-1:0]  fill_contig;
        logic [brf_pkg::CNT_W-1:0]  free_contig;
    } t_fifo_result;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_wr_en = 1'b0;
    logic [brf_pkg::CFG_W-1:0]       i_cfg_wr_data = '0;
    logic                            i_s_axis_tvalid = 1'b0;
    logic                            o_s_axis_tready;
    // operation[2:0], data_in[10:3], amount[23:11]
    logic [brf_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata = '0;
    logic                            o_m_axis_tvalid;
    logic                            i_m_axis_tready = 1'b0;
    // data_out[7:0], done_res[8], amount_done[21:9], peek_last[22], fill_level[35:23],
    // free_space[48:36], fill_contiguous[61:49], free_contiguous[74:62], zero[79:75]
    logic [brf_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata;

    byte_ring_fifo_core #(
        .DEPTH(STORE_DEPTH)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #(CLK_HALF) i_clk = 1'b1;
        #(CLK_HALF) i_clk = 1'b0;
    end

    // Shadow FIFO state
    logic [brf_pkg::CFG_W-1:0]  cap_log2_reg = brf_pkg::CAP_LOG2_RESET;
    int unsigned                tail_ptr = 0;
    int unsigned                head_ptr = 0;
    logic [brf_pkg::BYTE_W-1:0] byte_mem [STORE_DEPTH];
    bit                         byte_written [STORE_DEPTH];

    t_fifo_result expected_results[$];
    int           error_count = 0;
    int           items_sent = 0;
    int           sender_burst = 0;
    bit           sender_gaps_on = 1'b1;
    logic [8:0]   rx_cycle = '0;

    function automatic int unsigned capacity_bytes();
        int k;
        k = cap_log2_reg;
        if (k < 1) k = 1;
        if (k > MAX_CAP_LOG2) k = MAX_CAP_LOG2;
        return 1 << k;
    endfunction

    function automatic int unsigned fifo_fill();
        return (tail_ptr - head_ptr) & (2 * capacity_bytes() - 1);
    endfunction

    // Apply one operation to the shadow state and queue the result it gives
    task automatic predict_op(input logic [brf_pkg::OP_W-1:0] op,
                              input logic [brf_pkg::BYTE_W-1:0] din,
                              input logic [brf_pkg::CNT_W-1:0] amt);
        int unsigned cap, pmask, imask, fill, free_b, n, a, hrun, trun;
        t_fifo_result r;
        cap    = capacity_bytes();
        pmask  = 2 * cap - 1;
        imask  = cap - 1;
        fill   = fifo_fill();
        free_b = cap - fill;
        a      = amt;
        r.data_out    = '0;
        r.done        = 1'b0;
        r.amount_done = '0;
        r.peek_last   = 1'b0;
        case (op)
            brf_pkg::OP_PUSH: begin
                if (free_b > 0) begin
                    byte_mem[tail_ptr & imask]     = din;
                    byte_written[tail_ptr & imask] = 1'b1;
                    tail_ptr = (tail_ptr + 1) & pmask;
                    r.done   = 1'b1;
                end
            end
            brf_pkg::OP_POP: begin
                if (fill > 0) begin
                    r.data_out = byte_mem[head_ptr & imask];
                    head_ptr   = (head_ptr + 1) & pmask;
                    if (head_ptr == tail_ptr) begin
                        head_ptr = 0;
                        tail_ptr = 0;
                    end
                    r.done = 1'b1;
                end
            end
            brf_pkg::OP_PEEK: begin
                if (a < fill) begin
                    r.data_out  = byte_mem[(head_ptr + a) & imask];
                    r.peek_last = (a + 1 == fill);
                    r.done      = 1'b1;
                end
            end
            brf_pkg::OP_DRAIN: begin
                n = (a < fill) ? a : fill;
                head_ptr = (head_ptr + n) & pmask;
                if (head_ptr == tail_ptr) begin
                    head_ptr = 0;
                    tail_ptr = 0;
                end
                r.amount_done = brf_pkg::CNT_W'(n);
                r.done        = 1'b1;
            end
            brf_pkg::OP_POKE: begin
                if (a < free_b) begin
                    byte_mem[(tail_ptr + a) & imask]     = din;
                    byte_written[(tail_ptr + a) & imask] = 1'b1;
                    r.done = 1'b1;
                end
            end
            brf_pkg::OP_ADVANCE: begin
                n = (a < free_b) ? a : free_b;
                tail_ptr      = (tail_ptr + n) & pmask;
                r.amount_done = brf_pkg::CNT_W'(n);
                r.done        = 1'b1;
            end
            brf_pkg::OP_CLEAR: begin
                head_ptr = 0;
                tail_ptr = 0;
                r.done   = 1'b1;
            end
            default: ;
        endcase
        // Levels and runs before the wrap, after the operation
        fill   = fifo_fill();
        free_b = cap - fill;
        hrun   = cap - (head_ptr & imask);
        trun   = cap - (tail_ptr & imask);
        r.fill_level  = brf_pkg::CNT_W'(fill);
        r.free_space  = brf_pkg::CNT_W'(free_b);
        r.fill_contig = brf_pkg::CNT_W'((fill < hrun) ? fill : hrun);
        r.free_contig = brf_pkg::CNT_W'((free_b < trun) ? free_b : trun);
        expected_results.push_back(r);
    endtask

    // Send one item: optional gap at a burst boundary, then hold until taken
    task automatic send_item(input logic [brf_pkg::OP_W-1:0] op,
                             input logic [brf_pkg::BYTE_W-1:0] din,
                             input logic [brf_pkg::CNT_W-1:0] amt);
        int gap;
        gap = 0;
        if (sender_burst == 0) begin
            sender_burst = $urandom_range(1, 16);
            if (sender_gaps_on && $urandom_range(0, 2) != 0)
                gap = $urandom_range(1, 6);
        end
        sender_burst--;
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {amt, din, op};
        do @(posedge i_clk); while (!o_s_axis_tready);
        predict_op(op, din, amt);
        if (op != OP_UNUSED) items_sent++;
    endtask

    task automatic wait_results_drained();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (RESULT_LATENCY) @(posedge i_clk);
    endtask

    // Capacity change, only with nothing in flight; it also empties the FIFO
    task automatic write_capacity(input logic [brf_pkg::CFG_W-1:0] val);
        wait_results_drained();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= val;
        @(posedge i_clk);
        i_cfg_wr_en  <= 1'b0;
        cap_log2_reg = val;
        tail_ptr     = 0;
        head_ptr     = 0;
        @(posedge i_clk);
    endtask

    task automatic compare_field(input string name, input logic [brf_pkg::CNT_W-1:0] want,
                                 input logic [brf_pkg::CNT_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    task automatic check_result(input logic [brf_pkg::OUT_TDATA_W-1:0] td);
        t_fifo_result want;
        if (expected_results.size() == 0) begin
            $display("%0t: result item with none expected: expected nothing, actual %h",
                     $time, td);
            error_count++;
        end else begin
            want = expected_results.pop_front();
            compare_field("data_out", want.data_out, td[7:0]);
            compare_field("done_res", want.done, td[8]);
            compare_field("amount_done", want.amount_done, td[21:9]);
            compare_field("peek_last", want.peek_last, td[22]);
            compare_field("fill_level", want.fill_level, td[35:23]);
            compare_field("free_space", want.free_space, td[48:36]);
            compare_field("fill_contiguous", want.fill_contig, td[61:49]);
            compare_field("free_contiguous", want.free_contig, td[74:62]);
            compare_field("padding", '0, td[79:75]);
        end
    endtask

    // Result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            check_result(o_m_axis_tdata);
    end

    // Receiver stall pattern: open, random, periodic, then mostly stalled
    always @(posedge i_clk) begin
        rx_cycle <= rx_cycle + 1'b1;
        case (rx_cycle[8:7])
            2'd0: i_m_axis_tready <= 1'b1;
            2'd1: i_m_axis_tready <= 1'($urandom_range(0, 1));
            2'd2: i_m_axis_tready <= (rx_cycle[2:0] > 3'd2);
            default: i_m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Amount near the given boundary, or anywhere in the field
    function automatic logic [brf_pkg::CNT_W-1:0] pick_amount(input int unsigned edge_val);
        case ($urandom_range(0, 7))
            0: return '0;
            1: return brf_pkg::CNT_W'($urandom_range(0, AMOUNT_MAX));
            2: return brf_pkg::CNT_W'(edge_val);
            3: return brf_pkg::CNT_W'(edge_val + 1);
            4: return brf_pkg::CNT_W'((edge_val > 0) ? edge_val - 1 : 0);
            default: return brf_pkg::CNT_W'($urandom_range(0, (edge_val < 8) ? 8 : edge_val));
        endcase
    endfunction

    // Write a few bytes past the tail, then commit them with one advance; with no free space, push instead
    task automatic poke_then_advance(input int unsigned free_b);
        int unsigned k;
        k = $urandom_range(1, 6);
        if (k > free_b) k = free_b;
        if (k == 0) begin
            send_item(brf_pkg::OP_PUSH, brf_pkg::BYTE_W'($urandom_range(0, 255)), '0);
        end else begin
            for (int unsigned i = 0; i < k; i++)
                send_item(brf_pkg::OP_POKE, brf_pkg::BYTE_W'($urandom_range(0, 255)),
                          brf_pkg::CNT_W'(i));
            send_item(brf_pkg::OP_ADVANCE, brf_pkg::BYTE_W'($urandom_range(0, 255)),
                      brf_pkg::CNT_W'(k));
        end
    endtask

    // One random operation, or pokes then an advance; never reads a byte that was never written
    task automatic random_step();
        int unsigned cap, fill, free_b, imask, sel;
        logic [brf_pkg::BYTE_W-1:0] din;
        logic [brf_pkg::CNT_W-1:0]  amt;
        cap    = capacity_bytes();
        fill   = fifo_fill();
        free_b = cap - fill;
        imask  = cap - 1;
        din    = brf_pkg::BYTE_W'($urandom_range(0, 255));
        sel    = $urandom_range(0, 99);
        if (sel < 12) begin
            poke_then_advance(free_b);
        end else if (sel < 40) begin
            send_item(brf_pkg::OP_PUSH, din, brf_pkg::CNT_W'($urandom_range(0, AMOUNT_MAX)));
        end else if (sel < 62) begin
            // head byte skipped by an advance: step over it instead
            if (fill > 0 && !byte_written[head_ptr & imask])
                send_item(brf_pkg::OP_DRAIN, din, brf_pkg::CNT_W'(1));
            else
                send_item(brf_pkg::OP_POP, din,
                          brf_pkg::CNT_W'($urandom_range(0, AMOUNT_MAX)));
        end else if (sel < 74) begin
            amt = pick_amount(fill);
            if (amt < fill && !byte_written[(head_ptr + amt) & imask])
                amt = brf_pkg::CNT_W'(fill);
            send_item(brf_pkg::OP_PEEK, din, amt);
        end else if (sel < 82) begin
            send_item(brf_pkg::OP_DRAIN, din, pick_amount(fill));
        end else if (sel < 90) begin
            send_item(brf_pkg::OP_POKE, din, pick_amount(free_b));
        end else if (sel < 95) begin
            send_item(brf_pkg::OP_ADVANCE, din, pick_amount(free_b));
        end else if (sel < 98) begin
            send_item(brf_pkg::OP_CLEAR, din, brf_pkg::CNT_W'($urandom_range(0, AMOUNT_MAX)));
        end else begin
            send_item(OP_UNUSED, din, brf_pkg::CNT_W'($urandom_range(0, AMOUNT_MAX)));
        end
    endtask

    // Operations on an empty FIFO, including the unused code
    task automatic test_empty_fifo();
        send_item(brf_pkg::OP_POP, 8'h00, '0);
        send_item(brf_pkg::OP_PEEK, 8'h00, '0);
        send_item(brf_pkg::OP_DRAIN, 8'h00, brf_pkg::CNT_W'(AMOUNT_MAX));
        send_item(brf_pkg::OP_ADVANCE, 8'h00, '0);
        send_item(OP_UNUSED, 8'hFF, brf_pkg::CNT_W'(AMOUNT_MAX));
    endtask

    // Every operation but clear at full capacity, with refused peek and poke
    task automatic test_basic_ops();
        send_item(brf_pkg::OP_PUSH, 8'h00, '0);
        send_item(brf_pkg::OP_PUSH, 8'hFF, '0);
        send_item(brf_pkg::OP_PEEK, 8'h00, brf_pkg::CNT_W'(0));
        send_item(brf_pkg::OP_PEEK, 8'h00, brf_pkg::CNT_W'(1));
        send_item(brf_pkg::OP_PEEK, 8'h00, brf_pkg::CNT_W'(2));
        send_item(brf_pkg::OP_POKE, 8'hA5, brf_pkg::CNT_W'(0));
        send_item(brf_pkg::OP_POKE, 8'h5A, brf_pkg::CNT_W'(AMOUNT_MAX));
        send_item(brf_pkg::OP_ADVANCE, 8'h00, brf_pkg::CNT_W'(1));
        send_item(brf_pkg::OP_POP, 8'h00, '0);
        send_item(brf_pkg::OP_DRAIN, 8'h00, brf_pkg::CNT_W'(AMOUNT_MAX));
    endtask

    // Capacity code 0 acts as 1, codes above the store size clamp to it
    task automatic test_capacity_extremes();
        write_capacity(4'd0);
        send_item(brf_pkg::OP_PUSH, 8'h11, '0);
        send_item(brf_pkg::OP_PUSH, 8'h22, '0);
        send_item(brf_pkg::OP_PUSH, 8'h33, '0);
        send_item(brf_pkg::OP_POP, 8'h00, '0);
        send_item(brf_pkg::OP_PUSH, 8'h44, '0);
        send_item(brf_pkg::OP_CLEAR, 8'h00, '0);
        write_capacity(4'd15);
        send_item(brf_pkg::OP_ADVANCE, 8'h00, brf_pkg::CNT_W'(AMOUNT_MAX));
        send_item(brf_pkg::OP_PUSH, 8'h77, '0);
    endtask

    // Random traffic over several capacities, with all results drained mid-phase
    task automatic test_random_traffic();
        logic [brf_pkg::CFG_W-1:0] cap_settings [10];
        int phase_start;
        bit paused;
        cap_settings = '{4'd1, 4'd12, 4'd2, 4'd0, 4'd3, 4'd15, 4'd4, 4'd13, 4'd5, 4'd2};
        for (int p = 0; p < 10; p++) begin
            write_capacity(cap_settings[p]);
            sender_gaps_on = (p % 3 != 2);
            phase_start    = items_sent;
            paused         = 1'b0;
            while (items_sent - phase_start < ITEMS_PER_PHASE) begin
                random_step();
                if (!paused && items_sent - phase_start >= ITEMS_PER_PHASE / 2) begin
                    wait_results_drained();
                    paused = 1'b1;
                end
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_fifo();
        test_basic_ops();
        test_capacity_extremes();
        test_random_traffic();
        wait_results_drained();
        repeat (10) @(posedge i_clk);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog
    initial begin
        #(5_000_000);
        $display("Verification failed");
        $finish;
    end

endmodule
